// ===== sv/sdtl_pkg.sv =====
// sdtl_pkg: shared types, codes and constants of the sorted deadline timer list
// used by sdtl_ctrl, sdtl_dpath and sorted_deadline_timer_list_core
// no dependencies
package sdtl_pkg;

  // field widths fixed by the interface
  localparam int OP_W = 2;
  localparam int SLOT_W = 5;
  localparam int DL_W = 32;
  localparam int ST_W = 2;

  // default number of timer slots
  localparam int DEF_TIMER_SLOTS = 32;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    RC_DONE     = 2'd0,
    RC_EXPIRED  = 2'd1,
    RC_REJECTED = 2'd2,
    RC_NONE     = 2'd3
  } resp_code_t;

  // one entry of the ordered list
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DL_W-1:0]   dl;
  } entry_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_REM,
    S_INS_START,
    S_INS_CMP,
    S_INS_PUT,
    S_TICK_HEAD,
    S_TICK_LOOK,
    S_TICK_EMIT,
    S_TICK_DONE,
    S_TSHIFT,
    S_RESP_DONE,
    S_RESP_REJ,
    S_RESP_NONE
  } state_t;

  // list read address source; the walk index follows every read
  typedef enum logic [2:0] {
    RA_ZERO,
    RA_NEXT,
    RA_PREV,
    RA_TOP,
    RA_NCNT
  } rd_src_t;

  // list write address and data source
  typedef enum logic [2:0] {
    WR_SHIFT_UP,
    WR_NEW_UP,
    WR_NEW_ZERO,
    WR_SHIFT_DOWN,
    WR_COMPACT
  } wr_src_t;

  // armed count update
  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_SUB_N
  } cnt_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_req;
    logic       rd_go;
    rd_src_t    rd_src;
    logic       wr_go;
    wr_src_t    wr_src;
    cnt_op_t    cnt_op;
    logic       arm_set;
    logic       arm_clr;
    logic       exp_clr;
    logic       found_clr;
    logic       found_set;
    logic       ncnt_clr;
    logic       ncnt_inc;
    logic       cur_load;
    logic       last_we;
    logic       last_val;
    logic       out_load;
    resp_code_t out_kind;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic is_add;
    logic is_adjust;
    logic slot_ok;
    logic slot_armed;
    logic cnt_zero;
    logic cnt_one;
    logic idx_last;
    logic idx_zero;
    logic rd_le_dl;
    logic rd_le_now;
    logic rd_hit;
    logic found;
    logic n_all;
    logic last_flag;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/sdtl_ctrl.sv =====
// sdtl_ctrl: controller state machine of the sorted deadline timer list
// sequences list walks through commands to sdtl_dpath; depends on sdtl_pkg
module sdtl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdtl_pkg::stat_t stat,
  output sdtl_pkg::cmd_t  cmd
);

  sdtl_pkg::state_t state;
  sdtl_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdtl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdtl_pkg::S_IDLE: begin
        if (in_valid) state_next = sdtl_pkg::S_DECODE;
      end
      sdtl_pkg::S_DECODE: begin
        if (stat.is_tick) begin
          state_next = stat.cnt_zero ? sdtl_pkg::S_RESP_NONE : sdtl_pkg::S_TICK_HEAD;
        end else if (!stat.slot_ok) begin
          state_next = sdtl_pkg::S_RESP_REJ;
        end else if (stat.is_add) begin
          state_next = stat.slot_armed ? sdtl_pkg::S_RESP_REJ : sdtl_pkg::S_INS_START;
        end else begin
          state_next = stat.slot_armed ? sdtl_pkg::S_REM : sdtl_pkg::S_RESP_REJ;
        end
      end
      sdtl_pkg::S_REM: begin
        if (stat.idx_last) begin
          state_next = stat.is_adjust ? sdtl_pkg::S_INS_START : sdtl_pkg::S_RESP_DONE;
        end
      end
      sdtl_pkg::S_INS_START: begin
        state_next = stat.cnt_zero ? sdtl_pkg::S_RESP_DONE : sdtl_pkg::S_INS_CMP;
      end
      sdtl_pkg::S_INS_CMP: begin
        if (stat.rd_le_dl) begin
          state_next = sdtl_pkg::S_RESP_DONE;
        end else if (stat.idx_zero) begin
          state_next = sdtl_pkg::S_INS_PUT;
        end
      end
      sdtl_pkg::S_INS_PUT: begin
        state_next = sdtl_pkg::S_RESP_DONE;
      end
      sdtl_pkg::S_TICK_HEAD: begin
        if (!stat.rd_le_now) begin
          state_next = sdtl_pkg::S_RESP_NONE;
        end else if (stat.cnt_one) begin
          state_next = sdtl_pkg::S_TICK_EMIT;
        end else begin
          state_next = sdtl_pkg::S_TICK_LOOK;
        end
      end
      sdtl_pkg::S_TICK_LOOK: begin
        state_next = sdtl_pkg::S_TICK_EMIT;
      end
      sdtl_pkg::S_TICK_EMIT: begin
        if (stat.out_free) begin
          if (stat.last_flag) begin
            state_next = sdtl_pkg::S_TICK_DONE;
          end else if (!stat.idx_last) begin
            state_next = sdtl_pkg::S_TICK_LOOK;
          end
        end
      end
      sdtl_pkg::S_TICK_DONE: begin
        state_next = stat.n_all ? sdtl_pkg::S_IDLE : sdtl_pkg::S_TSHIFT;
      end
      sdtl_pkg::S_TSHIFT: begin
        if (stat.idx_last) state_next = sdtl_pkg::S_IDLE;
      end
      sdtl_pkg::S_RESP_DONE,
      sdtl_pkg::S_RESP_REJ,
      sdtl_pkg::S_RESP_NONE: begin
        if (stat.out_free) state_next = sdtl_pkg::S_IDLE;
      end
      default: state_next = sdtl_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      sdtl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_req = in_valid;
      end
      sdtl_pkg::S_DECODE: begin
        if (stat.is_tick) begin
          if (!stat.cnt_zero) begin
            cmd.rd_go = 1'b1;
            cmd.rd_src = sdtl_pkg::RA_ZERO;
            cmd.ncnt_clr = 1'b1;
            cmd.last_we = 1'b1;
            cmd.last_val = 1'b0;
          end
        end else if (stat.slot_ok) begin
          if (stat.is_add) begin
            cmd.arm_set = !stat.slot_armed;
          end else if (stat.slot_armed) begin
            cmd.rd_go = 1'b1;
            cmd.rd_src = sdtl_pkg::RA_ZERO;
            cmd.found_clr = 1'b1;
          end
        end
      end
      // forward walk that closes the gap left by the removed slot
      sdtl_pkg::S_REM: begin
        if (stat.found) begin
          cmd.wr_go = 1'b1;
          cmd.wr_src = sdtl_pkg::WR_SHIFT_DOWN;
        end
        cmd.found_set = stat.rd_hit;
        if (stat.idx_last) begin
          cmd.cnt_op = sdtl_pkg::CNT_DEC;
          cmd.arm_clr = !stat.is_adjust;
        end else begin
          cmd.rd_go = 1'b1;
          cmd.rd_src = sdtl_pkg::RA_NEXT;
        end
      end
      sdtl_pkg::S_INS_START: begin
        if (stat.cnt_zero) begin
          cmd.wr_go = 1'b1;
          cmd.wr_src = sdtl_pkg::WR_NEW_ZERO;
          cmd.cnt_op = sdtl_pkg::CNT_INC;
        end else begin
          cmd.rd_go = 1'b1;
          cmd.rd_src = sdtl_pkg::RA_TOP;
        end
      end
      // backward walk: later deadlines move up one place
      sdtl_pkg::S_INS_CMP: begin
        cmd.wr_go = 1'b1;
        if (stat.rd_le_dl) begin
          cmd.wr_src = sdtl_pkg::WR_NEW_UP;
          cmd.cnt_op = sdtl_pkg::CNT_INC;
        end else begin
          cmd.wr_src = sdtl_pkg::WR_SHIFT_UP;
          if (!stat.idx_zero) begin
            cmd.rd_go = 1'b1;
            cmd.rd_src = sdtl_pkg::RA_PREV;
          end
        end
      end
      sdtl_pkg::S_INS_PUT: begin
        cmd.wr_go = 1'b1;
        cmd.wr_src = sdtl_pkg::WR_NEW_ZERO;
        cmd.cnt_op = sdtl_pkg::CNT_INC;
      end
      sdtl_pkg::S_TICK_HEAD: begin
        if (stat.rd_le_now) begin
          cmd.cur_load = 1'b1;
          if (stat.cnt_one) begin
            cmd.last_we = 1'b1;
            cmd.last_val = 1'b1;
          end else begin
            cmd.rd_go = 1'b1;
            cmd.rd_src = sdtl_pkg::RA_NEXT;
          end
        end
      end
      // the entry behind the current one decides whether it is the last
      sdtl_pkg::S_TICK_LOOK: begin
        cmd.last_we = 1'b1;
        cmd.last_val = !stat.rd_le_now;
      end
      sdtl_pkg::S_TICK_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = sdtl_pkg::RC_EXPIRED;
          cmd.exp_clr = 1'b1;
          cmd.ncnt_inc = 1'b1;
          if (!stat.last_flag) begin
            cmd.cur_load = 1'b1;
            if (stat.idx_last) begin
              cmd.last_we = 1'b1;
              cmd.last_val = 1'b1;
            end else begin
              cmd.rd_go = 1'b1;
              cmd.rd_src = sdtl_pkg::RA_NEXT;
            end
          end
        end
      end
      sdtl_pkg::S_TICK_DONE: begin
        if (stat.n_all) begin
          cmd.cnt_op = sdtl_pkg::CNT_SUB_N;
        end else begin
          cmd.rd_go = 1'b1;
          cmd.rd_src = sdtl_pkg::RA_NCNT;
        end
      end
      // move the survivors to the head of the list
      sdtl_pkg::S_TSHIFT: begin
        cmd.wr_go = 1'b1;
        cmd.wr_src = sdtl_pkg::WR_COMPACT;
        if (stat.idx_last) begin
          cmd.cnt_op = sdtl_pkg::CNT_SUB_N;
        end else begin
          cmd.rd_go = 1'b1;
          cmd.rd_src = sdtl_pkg::RA_NEXT;
        end
      end
      sdtl_pkg::S_RESP_DONE: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = sdtl_pkg::RC_DONE;
      end
      sdtl_pkg::S_RESP_REJ: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = sdtl_pkg::RC_REJECTED;
      end
      sdtl_pkg::S_RESP_NONE: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = sdtl_pkg::RC_NONE;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/sdtl_dpath.sv =====
// sdtl_dpath: datapath of the sorted deadline timer list
// ordered list memory, armed bits, walk counters and result register; depends on sdtl_pkg
module sdtl_dpath #(
  parameter int TIMER_SLOTS = sdtl_pkg::DEF_TIMER_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sdtl_pkg::cmd_t                cmd,
  output sdtl_pkg::stat_t               stat,
  input  logic [sdtl_pkg::OP_W-1:0]     operation,
  input  logic [sdtl_pkg::SLOT_W-1:0]   slot,
  input  logic [sdtl_pkg::DL_W-1:0]     deadline,
  input  logic [sdtl_pkg::DL_W-1:0]     current_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdtl_pkg::ST_W-1:0]     status,
  output logic [sdtl_pkg::SLOT_W-1:0]   slot_out,
  output logic [sdtl_pkg::DL_W-1:0]     deadline_out,
  output logic                          last
);

  localparam int AW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  // request registers
  sdtl_pkg::op_t               r_op;
  logic [sdtl_pkg::SLOT_W-1:0] r_slot;
  logic [sdtl_pkg::DL_W-1:0]   r_dl;
  logic [sdtl_pkg::DL_W-1:0]   r_now;

  // list state and walk registers
  sdtl_pkg::entry_t lm [TIMER_SLOTS];
  sdtl_pkg::entry_t rd_data;
  sdtl_pkg::entry_t cur;
  logic [TIMER_SLOTS-1:0] armed;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] ncnt;
  logic found;
  logic last_flag;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] wr_addr;
  sdtl_pkg::entry_t wr_data;
  sdtl_pkg::entry_t new_entry;
  logic [AW-1:0] slot_i;
  logic [AW-1:0] cur_i;
  logic out_free;

  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);
  assign count_m1 = count - CW'(1);
  assign new_entry = '{slot: r_slot, dl: r_dl};
  assign slot_i = AW'(r_slot);
  assign cur_i = AW'(cur.slot);
  assign out_free = !out_valid || out_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r_op <= sdtl_pkg::op_t'(operation);
      r_slot <= slot;
      r_dl <= deadline;
      r_now <= current_time;
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_src)
      sdtl_pkg::RA_ZERO: rd_addr = '0;
      sdtl_pkg::RA_NEXT: rd_addr = idx_inc;
      sdtl_pkg::RA_PREV: rd_addr = idx_dec;
      sdtl_pkg::RA_TOP:  rd_addr = count_m1;
      sdtl_pkg::RA_NCNT: rd_addr = ncnt;
      default:           rd_addr = '0;
    endcase
  end

  // write address and data select
  always_comb begin
    case (cmd.wr_src)
      sdtl_pkg::WR_SHIFT_UP: begin
        wr_addr = idx_inc;
        wr_data = rd_data;
      end
      sdtl_pkg::WR_NEW_UP: begin
        wr_addr = idx_inc;
        wr_data = new_entry;
      end
      sdtl_pkg::WR_NEW_ZERO: begin
        wr_addr = '0;
        wr_data = new_entry;
      end
      sdtl_pkg::WR_SHIFT_DOWN: begin
        wr_addr = idx_dec;
        wr_data = rd_data;
      end
      sdtl_pkg::WR_COMPACT: begin
        wr_addr = idx - ncnt;
        wr_data = rd_data;
      end
      default: begin
        wr_addr = '0;
        wr_data = rd_data;
      end
    endcase
  end

  // ordered list memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_go) lm[wr_addr[AW-1:0]] <= wr_data;
    if (cmd.rd_go) rd_data <= lm[rd_addr[AW-1:0]];
  end

  // walk index follows the read address
  always_ff @(posedge clk) begin
    if (cmd.rd_go) idx <= rd_addr;
    if (cmd.cur_load) cur <= rd_data;
  end

  // armed count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        sdtl_pkg::CNT_HOLD:  count <= count;
        sdtl_pkg::CNT_INC:   count <= count + CW'(1);
        sdtl_pkg::CNT_DEC:   count <= count_m1;
        sdtl_pkg::CNT_SUB_N: count <= count - ncnt;
        default:             count <= count;
      endcase
    end
  end

  // armed bits per slot
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else begin
      if (cmd.arm_set) armed[slot_i] <= 1'b1;
      if (cmd.arm_clr) armed[slot_i] <= 1'b0;
      if (cmd.exp_clr) armed[cur_i] <= 1'b0;
    end
  end

  // walk flags and expiry counter
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      last_flag <= 1'b0;
      ncnt <= '0;
    end else begin
      if (cmd.found_clr) found <= 1'b0;
      else if (cmd.found_set) found <= 1'b1;
      if (cmd.last_we) last_flag <= cmd.last_val;
      if (cmd.ncnt_clr) ncnt <= '0;
      else if (cmd.ncnt_inc) ncnt <= ncnt + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_kind;
      case (cmd.out_kind)
        sdtl_pkg::RC_EXPIRED: begin
          slot_out <= cur.slot;
          deadline_out <= cur.dl;
          last <= last_flag;
        end
        sdtl_pkg::RC_NONE: begin
          slot_out <= '0;
          deadline_out <= '0;
          last <= 1'b1;
        end
        default: begin
          slot_out <= r_slot;
          deadline_out <= '0;
          last <= 1'b1;
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    stat.is_tick = (r_op == sdtl_pkg::OP_TICK);
    stat.is_add = (r_op == sdtl_pkg::OP_ADD);
    stat.is_adjust = (r_op == sdtl_pkg::OP_ADJUST);
    stat.slot_ok = (32'(r_slot) < 32'(TIMER_SLOTS));
    stat.slot_armed = armed[slot_i];
    stat.cnt_zero = (count == '0);
    stat.cnt_one = (count == CW'(1));
    stat.idx_last = (idx == count_m1);
    stat.idx_zero = (idx == '0);
    stat.rd_le_dl = (rd_data.dl <= r_dl);
    stat.rd_le_now = (rd_data.dl <= r_now);
    stat.rd_hit = (rd_data.slot == r_slot);
    stat.found = found;
    stat.n_all = (ncnt == count);
    stat.last_flag = last_flag;
    stat.out_free = out_free;
  end

endmodule

// ===== sv/sorted_deadline_timer_list_core.sv =====
// Sorted deadline timer list: keeps up to TIMER_SLOTS timers in order of absolute
// deadline, later add or adjust behind earlier ones on equal deadlines. One request
// is worked at a time; the list lives in a memory with one write and one registered
// read port, so the remove, insert and compact walks move one list entry per cycle,
// while a tick waits for a free output register before it emits each expired slot and
// then moves the remaining timers to the head. A new request is taken while the last
// result still waits in the output register.
// depends on sdtl_pkg, sdtl_ctrl and sdtl_dpath
module sorted_deadline_timer_list_core #(
  parameter int TIMER_SLOTS = sdtl_pkg::DEF_TIMER_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sdtl_pkg::OP_W-1:0]     operation,
  input  logic [sdtl_pkg::SLOT_W-1:0]   slot,
  input  logic [sdtl_pkg::DL_W-1:0]     deadline,
  input  logic [sdtl_pkg::DL_W-1:0]     current_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdtl_pkg::ST_W-1:0]     status,
  output logic [sdtl_pkg::SLOT_W-1:0]   slot_out,
  output logic [sdtl_pkg::DL_W-1:0]     deadline_out,
  output logic                          last
);

  sdtl_pkg::cmd_t  cmd;
  sdtl_pkg::stat_t stat;

  // request sequencing
  sdtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // list storage and result register
  sdtl_dpath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .slot         (slot),
    .deadline     (deadline),
    .current_time (current_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot_out     (slot_out),
    .deadline_out (deadline_out),
    .last         (last)
  );

endmodule

// ===== tb/sorted_deadline_timer_list_core_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of sorted_deadline_timer_list_core: a directed table, then
// random add, adjust, delete and tick requests under varied stalls, checked by a predictor
// depends on sdtl_pkg and sorted_deadline_timer_list_core
module sorted_deadline_timer_list_core_test;

  localparam int TIMER_SLOTS = sdtl_pkg::DEF_TIMER_SLOTS;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 150;
  localparam longint TIMEOUT_NS = 64'd10_000_000;
  localparam int DIRECTED_ROWS = 24;

  // one result as seen on the output side
  typedef struct packed {
    sdtl_pkg::resp_code_t        code;
    logic [sdtl_pkg::SLOT_W-1:0] slot;
    logic [sdtl_pkg::DL_W-1:0]   dl;
    logic                        fin;
  } timer_result_t;

  // one row of the directed table; typed rows carry their single result
  typedef struct packed {
    sdtl_pkg::op_t               op;
    logic [sdtl_pkg::SLOT_W-1:0] req_slot;
    logic [sdtl_pkg::DL_W-1:0]   dl;
    logic [sdtl_pkg::DL_W-1:0]   now;
    logic                        typed;
    sdtl_pkg::resp_code_t        code;
    logic [sdtl_pkg::SLOT_W-1:0] exp_slot;
  } stim_row_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [sdtl_pkg::OP_W-1:0]   operation;
  logic [sdtl_pkg::SLOT_W-1:0] slot;
  logic [sdtl_pkg::DL_W-1:0]   deadline;
  logic [sdtl_pkg::DL_W-1:0]   current_time;
  logic                        out_valid;
  logic                        out_ready;
  logic [sdtl_pkg::ST_W-1:0]   status;
  logic [sdtl_pkg::SLOT_W-1:0] slot_out;
  logic [sdtl_pkg::DL_W-1:0]   deadline_out;
  logic                        last;

  // predicted timer state
  logic [sdtl_pkg::DL_W-1:0]   timer_deadline [TIMER_SLOTS];
  logic                        timer_armed [TIMER_SLOTS];
  logic [sdtl_pkg::SLOT_W-1:0] deadline_order [TIMER_SLOTS];
  int                          armed_total;

  timer_result_t     step_results[$];
  timer_result_t     due_results[$];
  stim_row_t         directed_rows [DIRECTED_ROWS];

  int                        mismatch_count = 0;
  int                        send_idle_pct = 0;
  int                        stall_pct = 0;
  int                        hold_gen = 0;
  logic [sdtl_pkg::DL_W-1:0] clock_base = 32'd1000;

  sorted_deadline_timer_list_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .slot         (slot),
    .deadline     (deadline),
    .current_time (current_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot_out     (slot_out),
    .deadline_out (deadline_out),
    .last         (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #TIMEOUT_NS;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // work out the results of one request and update the predicted list
  task automatic predict_timer_request(input sdtl_pkg::op_t op,
                                       input logic [sdtl_pkg::SLOT_W-1:0] s,
                                       input logic [sdtl_pkg::DL_W-1:0] dl,
                                       input logic [sdtl_pkg::DL_W-1:0] now);
    int n;
    int i;
    int j;
    int pos;
    step_results.delete();
    if (op == sdtl_pkg::OP_TICK) begin
      n = 0;
      while (n < armed_total && timer_deadline[deadline_order[n]] <= now)
        n++;
      if (n == 0) begin
        step_results.push_back('{sdtl_pkg::RC_NONE, 5'd0, 32'd0, 1'b1});
      end else begin
        for (i = 0; i < n; i++) begin
          step_results.push_back('{sdtl_pkg::RC_EXPIRED, deadline_order[i],
                                   timer_deadline[deadline_order[i]], 1'(i == n - 1)});
          timer_armed[deadline_order[i]] = 1'b0;
        end
        for (i = n; i < armed_total; i++)
          deadline_order[i - n] = deadline_order[i];
        armed_total -= n;
      end
    end else if ((op == sdtl_pkg::OP_ADD) == timer_armed[s]) begin
      // add to an armed slot, or adjust or delete of a free one
      step_results.push_back('{sdtl_pkg::RC_REJECTED, s, 32'd0, 1'b1});
    end else begin
      // adjust and delete first take the slot out of the list
      if (op != sdtl_pkg::OP_ADD) begin
        j = 0;
        for (i = 0; i < armed_total; i++) begin
          if (deadline_order[i] != s) begin
            deadline_order[j] = deadline_order[i];
            j++;
          end
        end
        armed_total = j;
      end
      if (op == sdtl_pkg::OP_DELETE) begin
        timer_armed[s] = 1'b0;
      end else begin
        // place behind every timer whose deadline is not after the new one
        timer_deadline[s] = dl;
        timer_armed[s] = 1'b1;
        pos = 0;
        while (pos < armed_total && timer_deadline[deadline_order[pos]] <= dl)
          pos++;
        for (i = armed_total; i > pos; i--)
          deadline_order[i] = deadline_order[i - 1];
        deadline_order[pos] = s;
        armed_total++;
      end
      step_results.push_back('{sdtl_pkg::RC_DONE, s, 32'd0, 1'b1});
    end
  endtask

  // offer one request, wait for it to be taken, then queue its results
  task automatic offer_request(input sdtl_pkg::op_t op,
                               input logic [sdtl_pkg::SLOT_W-1:0] s,
                               input logic [sdtl_pkg::DL_W-1:0] dl,
                               input logic [sdtl_pkg::DL_W-1:0] now,
                               input logic typed, input sdtl_pkg::resp_code_t code,
                               input logic [sdtl_pkg::SLOT_W-1:0] exp_slot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    slot         <= s;
    deadline     <= dl;
    current_time <= now;
    do @(posedge clk); while (!in_ready);
    predict_timer_request(op, s, dl, now);
    if (typed)
      due_results.push_back('{code, exp_slot, 32'd0, 1'b1});
    else
      foreach (step_results[i]) due_results.push_back(step_results[i]);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // a slot in the wanted state, or any slot when none is
  function automatic logic [sdtl_pkg::SLOT_W-1:0] pick_slot(input logic want_armed);
    int start;
    int k;
    logic [sdtl_pkg::SLOT_W-1:0] idx;
    start = $urandom_range(0, TIMER_SLOTS - 1);
    for (k = 0; k < TIMER_SLOTS; k++) begin
      idx = sdtl_pkg::SLOT_W'(start + k);
      if (timer_armed[idx] == want_armed) return idx;
    end
    return sdtl_pkg::SLOT_W'($urandom_range(0, TIMER_SLOTS - 1));
  endfunction

  // mostly near future, some ties, some anywhere, some extremes
  function automatic logic [sdtl_pkg::DL_W-1:0] pick_deadline();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return clock_base + $urandom_range(0, 400);
    if (r < 75) return clock_base + $urandom_range(0, 3);
    if (r < 88) return $urandom;
    if (r < 94) return '0;
    return '1;
  endfunction

  task automatic offer_random(input int count);
    sdtl_pkg::op_t op;
    logic [sdtl_pkg::SLOT_W-1:0] s;
    logic [sdtl_pkg::DL_W-1:0] now;
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      op = (r < 40) ? sdtl_pkg::OP_ADD : (r < 60) ? sdtl_pkg::OP_ADJUST :
           (r < 75) ? sdtl_pkg::OP_DELETE : sdtl_pkg::OP_TICK;
      if ($urandom_range(0, 99) < 85)
        s = pick_slot(op != sdtl_pkg::OP_ADD);
      else
        s = sdtl_pkg::SLOT_W'($urandom_range(0, TIMER_SLOTS - 1));
      now = $urandom;
      if (op == sdtl_pkg::OP_TICK) begin
        clock_base = clock_base + $urandom_range(0, 60);
        r = $urandom_range(0, 99);
        now = (r < 85) ? clock_base : (r < 95) ? sdtl_pkg::DL_W'($urandom) : '1;
      end
      offer_request(op, s, pick_deadline(), now, 1'b0, sdtl_pkg::RC_DONE, 5'd0);
    end
  endtask

  // result side: random stalls, long hold-offs on request, checking
  initial begin : result_side
    timer_result_t want;
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing outstanding, slot", 32'(slot_out), 0);
        end else begin
          want = due_results.pop_front();
          if (status !== want.code)
            report_mismatch("status", 32'(status), 32'(want.code));
          if (slot_out !== want.slot)
            report_mismatch("slot_out", 32'(slot_out), 32'(want.slot));
          if (deadline_out !== want.dl)
            report_mismatch("deadline_out", deadline_out, want.dl);
          if (last !== want.fin)
            report_mismatch("last", 32'(last), 32'(want.fin));
        end
      end
      if (hold_seen != hold_gen) begin
        hold_seen = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // request side
  initial begin : request_side
    int k;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    operation    <= sdtl_pkg::OP_ADD;
    slot         <= '0;
    deadline     <= '0;
    current_time <= '0;
    for (k = 0; k < TIMER_SLOTS; k++) timer_armed[k] = 1'b0;
    armed_total = 0;

    // op, slot, deadline, time, typed, status, slot_out
    directed_rows = '{
      '{sdtl_pkg::OP_TICK,   5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
        sdtl_pkg::RC_NONE,     5'd0},
      '{sdtl_pkg::OP_TICK,   5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        sdtl_pkg::RC_NONE,     5'd0},
      '{sdtl_pkg::OP_ADJUST, 5'd5,  32'd123,       32'h0000_0000, 1'b1,
        sdtl_pkg::RC_REJECTED, 5'd5},
      '{sdtl_pkg::OP_DELETE, 5'd31, 32'h0000_0000, 32'h0000_0000, 1'b1,
        sdtl_pkg::RC_REJECTED, 5'd31},
      '{sdtl_pkg::OP_ADD,    5'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd0},
      '{sdtl_pkg::OP_ADD,    5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
        sdtl_pkg::RC_REJECTED, 5'd0},
      '{sdtl_pkg::OP_ADD,    5'd31, 32'h0000_0000, 32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd31},
      '{sdtl_pkg::OP_ADD,    5'd10, 32'd100,       32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd10},
      '{sdtl_pkg::OP_ADD,    5'd11, 32'd100,       32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd11},
      '{sdtl_pkg::OP_ADD,    5'd12, 32'd50,        32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd12},
      // same deadline again: moves behind its equal
      '{sdtl_pkg::OP_ADJUST, 5'd10, 32'd100,       32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd10},
      // earlier deadline accepted too
      '{sdtl_pkg::OP_ADJUST, 5'd0,  32'd20,        32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd0},
      '{sdtl_pkg::OP_TICK,   5'd0,  32'h0000_0000, 32'd19,        1'b0,
        sdtl_pkg::RC_DONE,     5'd0},
      '{sdtl_pkg::OP_TICK,   5'd0,  32'h0000_0000, 32'd100,       1'b0,
        sdtl_pkg::RC_DONE,     5'd0},
      '{sdtl_pkg::OP_TICK,   5'd0,  32'h0000_0000, 32'd100,       1'b1,
        sdtl_pkg::RC_NONE,     5'd0},
      '{sdtl_pkg::OP_DELETE, 5'd31, 32'h0000_0000, 32'h0000_0000, 1'b1,
        sdtl_pkg::RC_REJECTED, 5'd31},
      '{sdtl_pkg::OP_ADD,    5'd31, 32'd7,         32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd31},
      '{sdtl_pkg::OP_ADJUST, 5'd31, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd31},
      '{sdtl_pkg::OP_ADD,    5'd1,  32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
        sdtl_pkg::RC_DONE,     5'd1},
      '{sdtl_pkg::OP_ADD,    5'd2,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1,
        sdtl_pkg::RC_DONE,     5'd2},
      '{sdtl_pkg::OP_DELETE, 5'd1,  32'h0000_0000, 32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd1},
      '{sdtl_pkg::OP_TICK,   5'd0,  32'h0000_0000, 32'hFFFF_FFFE, 1'b0,
        sdtl_pkg::RC_DONE,     5'd0},
      '{sdtl_pkg::OP_TICK,   5'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0,
        sdtl_pkg::RC_DONE,     5'd0},
      '{sdtl_pkg::OP_ADD,    5'd1,  32'd1,         32'h0000_0000, 1'b1,
        sdtl_pkg::RC_DONE,     5'd1}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i])
      offer_request(directed_rows[i].op, directed_rows[i].req_slot, directed_rows[i].dl,
                    directed_rows[i].now, directed_rows[i].typed, directed_rows[i].code,
                    directed_rows[i].exp_slot);
    wait_for_drain();

    // random phases with different idling
    offer_random(20);
    wait_for_drain();
    send_idle_pct = 88;
    offer_random(20);
    wait_for_drain();
    send_idle_pct = 0;
    stall_pct = 88;
    offer_random(20);
    wait_for_drain();
    send_idle_pct = 28;
    stall_pct = 28;
    offer_random(20);
    wait_for_drain();

    // receiver holds off while the list is filled, then one re-time and a full expiry
    send_idle_pct = 0;
    stall_pct = 0;
    hold_gen++;
    while (armed_total < TIMER_SLOTS)
      offer_request(sdtl_pkg::OP_ADD, pick_slot(1'b0), pick_deadline(), $urandom, 1'b0,
                    sdtl_pkg::RC_DONE, 5'd0);
    offer_request(sdtl_pkg::OP_ADJUST, pick_slot(1'b1), pick_deadline(), $urandom, 1'b0,
                  sdtl_pkg::RC_DONE, 5'd0);
    offer_request(sdtl_pkg::OP_TICK, sdtl_pkg::SLOT_W'($urandom), $urandom, '1, 1'b0,
                  sdtl_pkg::RC_DONE, 5'd0);
    wait_for_drain();

    send_idle_pct = 28;
    stall_pct = 28;
    offer_random(15);
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
